>>> hw/rtl/cspd_pkg.sv
`default_nettype none

package cspd_pkg;

  localparam int FRAC_BITS = 8;
  localparam int HIST_TAPS = 4;

  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 11;
  localparam int PERIOD_W = 4;
  localparam int POS_W    = 11;
  localparam int GYRO_W   = 16;
  localparam int DRIVE_W  = 12;
  localparam int TGT_W    = 40;
  localparam int OPB_W    = 48;
  localparam int MUL_B_W  = OPB_W + 1;
  localparam int CHUNK_W  = 24;
  localparam int PROD_W   = GAIN_W + 1 + CHUNK_W + 1;
  localparam int ACC_W    = 66;
  localparam int Q_W      = ACC_W - 2 * FRAC_BITS;
  localparam int TAP_W    = (HIST_TAPS > 1) ? $clog2(HIST_TAPS) : 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_OUTER_GAIN_NORMAL = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTER_GAIN_ZEBRA  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_WEIGHT     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GYRO_WEIGHT       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_KP          = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_KD          = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_LIMIT       = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTER_PERIOD      = 3'd7;

  localparam logic [GAIN_W-1:0]   RST_GAIN_NORMAL = 16'd1280;
  localparam logic [GAIN_W-1:0]   RST_GAIN_ZEBRA  = 16'd2560;
  localparam logic [GAIN_W-1:0]   RST_TGT_WEIGHT  = 16'd2637;
  localparam logic [GAIN_W-1:0]   RST_GYRO_WEIGHT = 16'd74;
  localparam logic [GAIN_W-1:0]   RST_INNER_KP    = 16'd115;
  localparam logic [GAIN_W-1:0]   RST_INNER_KD    = 16'd115;
  localparam logic [LIMIT_W-1:0]  RST_LIMIT       = 11'd550;
  localparam logic [PERIOD_W-1:0] RST_PERIOD      = 4'd3;

  // rounded fixed point constants
  localparam int C03_I = ((3 << FRAC_BITS) * 2 + 10) / 20;
  localparam int W0_I  = ((8 << FRAC_BITS) * 2 + 10) / 20;
  localparam int W1_I  = ((1 << FRAC_BITS) * 2 + 10) / 20;
  localparam int W2_I  = ((6 << FRAC_BITS) * 2 + 100) / 200;
  localparam int W3_I  = ((4 << FRAC_BITS) * 2 + 100) / 200;

  localparam logic [GAIN_W-1:0] C03 = GAIN_W'(C03_I);

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_n;
    logic [GAIN_W-1:0]   gain_z;
    logic [GAIN_W-1:0]   tgt_w;
    logic [GAIN_W-1:0]   gyro_w;
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   kd;
    logic [LIMIT_W-1:0]  limit;
    logic [PERIOD_W-1:0] period;
  } cfg_regs_t;

  typedef struct packed {
    logic en;
    logic hi;
    logic clr;
    logic shr;
  } mac_ctrl_t;

  function automatic logic [GAIN_W-1:0] tap_weight(input int k);
    logic [GAIN_W-1:0] w;
    case (k)
      0: w = GAIN_W'(W0_I);
      1: w = GAIN_W'(W1_I);
      2: w = GAIN_W'(W2_I);
      3: w = GAIN_W'(W3_I);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cspd_if.sv
`default_nettype none

interface cspd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cspd_pkg::POS_W-1:0]   pos_error;
  logic signed [cspd_pkg::GYRO_W-1:0]  gyro_z;
  logic                                mode;

  modport source (output valid, output pos_error, output gyro_z, output mode, input ready);
  modport sink (input valid, input pos_error, input gyro_z, input mode, output ready);
endinterface

interface cspd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cspd_pkg::DRIVE_W-1:0] drive;
  logic                                clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink (input valid, input drive, input clamped, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cspd_mac.sv
`default_nettype none

module cspd_mac (
  input  wire                                    clk,
  input  cspd_pkg::mac_ctrl_t                    ctrl,
  input  wire        [cspd_pkg::GAIN_W-1:0]      op_a,
  input  wire signed [cspd_pkg::MUL_B_W-1:0]     op_b,
  output logic signed [cspd_pkg::ACC_W-1:0]      acc
);

  logic signed [cspd_pkg::CHUNK_W:0]   chunk;
  logic signed [cspd_pkg::GAIN_W:0]    a_s;
  logic signed [cspd_pkg::PROD_W-1:0]  prod;
  logic signed [cspd_pkg::ACC_W-1:0]   prod_ext;
  logic signed [cspd_pkg::ACC_W-1:0]   addend;
  logic signed [cspd_pkg::ACC_W-1:0]   acc_r;
  logic signed [cspd_pkg::ACC_W-1:0]   acc_nxt;

  // low chunk unsigned, high chunk carries the sign
  always_comb begin
    if (ctrl.hi) begin
      chunk = op_b[cspd_pkg::MUL_B_W-1:cspd_pkg::CHUNK_W];
    end else begin
      chunk = {1'b0, op_b[cspd_pkg::CHUNK_W-1:0]};
    end
  end

  assign a_s  = {1'b0, op_a};
  assign prod = a_s * chunk;
  assign prod_ext = {{(cspd_pkg::ACC_W-cspd_pkg::PROD_W){prod[cspd_pkg::PROD_W-1]}}, prod};

  always_comb begin
    addend = ctrl.hi ? (prod_ext <<< cspd_pkg::CHUNK_W) : prod_ext;
    if (ctrl.shr) begin
      acc_nxt = acc_r >>> cspd_pkg::FRAC_BITS;
    end else if (ctrl.en) begin
      acc_nxt = (ctrl.clr ? '0 : acc_r) + addend;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

>>> hw/rtl/cspd_seq.sv
`default_nettype none

module cspd_seq (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  cspd_pkg::cfg_regs_t                   cfg,
  input  wire                                   start,
  input  wire signed [cspd_pkg::POS_W-1:0]      pos_in,
  input  wire signed [cspd_pkg::GYRO_W-1:0]     gyro_in,
  input  wire                                   mode_in,
  input  wire                                   out_free,
  input  wire signed [cspd_pkg::ACC_W-1:0]      acc,
  output logic                                  busy,
  output cspd_pkg::mac_ctrl_t                   mac_ctrl,
  output logic       [cspd_pkg::GAIN_W-1:0]     op_a,
  output logic signed [cspd_pkg::MUL_B_W-1:0]   op_b,
  output logic                                  done,
  output logic signed [cspd_pkg::DRIVE_W-1:0]   drive,
  output logic                                  clamped
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_WB   = 2'd3;

  localparam logic [2:0] OP_GD  = 3'd0;
  localparam logic [2:0] OP_TP  = 3'd1;
  localparam logic [2:0] OP_TD  = 3'd2;
  localparam logic [2:0] OP_EW  = 3'd3;
  localparam logic [2:0] OP_EG  = 3'd4;
  localparam logic [2:0] OP_PK  = 3'd5;
  localparam logic [2:0] OP_PD  = 3'd6;
  localparam logic [2:0] OP_TAP = 3'd7;

  localparam logic [cspd_pkg::TAP_W-1:0] LAST_TAP = cspd_pkg::TAP_W'(cspd_pkg::HIST_TAPS - 1);

  // symmetric limits of a 48 bit loop value
  localparam logic signed [cspd_pkg::ACC_W-1:0] OPB_MAX =
    {{(cspd_pkg::ACC_W-cspd_pkg::OPB_W+1){1'b0}}, {(cspd_pkg::OPB_W-1){1'b1}}};
  localparam logic signed [cspd_pkg::ACC_W-1:0] OPB_MIN = -OPB_MAX;

  function automatic logic signed [cspd_pkg::OPB_W-1:0] sat_opb(
    input logic signed [cspd_pkg::ACC_W-1:0] v
  );
    logic signed [cspd_pkg::OPB_W-1:0] r;
    if (v > OPB_MAX) begin
      r = OPB_MAX[cspd_pkg::OPB_W-1:0];
    end else if (v < OPB_MIN) begin
      r = OPB_MIN[cspd_pkg::OPB_W-1:0];
    end else begin
      r = v[cspd_pkg::OPB_W-1:0];
    end
    return r;
  endfunction

  logic [1:0]                            phase_r, phase_nxt;
  logic [2:0]                            op_r, op_nxt;
  logic [cspd_pkg::TAP_W-1:0]            tap_r, tap_nxt;
  logic [cspd_pkg::PERIOD_W-1:0]         tick_r, tick_nxt;
  logic signed [cspd_pkg::POS_W-1:0]     prev_r, prev_nxt;
  logic signed [cspd_pkg::TGT_W-1:0]     target_r, target_nxt;
  logic signed [cspd_pkg::OPB_W-1:0]     last_r, last_nxt;
  logic signed [cspd_pkg::OPB_W-1:0]     hist_r [cspd_pkg::HIST_TAPS-1];
  logic signed [cspd_pkg::OPB_W-1:0]     hist_nxt [cspd_pkg::HIST_TAPS-1];
  logic signed [cspd_pkg::OPB_W-1:0]     err_r, err_nxt;
  logic signed [cspd_pkg::OPB_W-1:0]     pd_r, pd_nxt;
  logic [cspd_pkg::GAIN_W-1:0]           gd_r, gd_nxt;
  logic signed [cspd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic signed [cspd_pkg::GYRO_W-1:0]    gyro_r, gyro_nxt;
  logic                                  mode_r, mode_nxt;

  logic                                  do_outer;
  logic                                  last_step;
  logic [cspd_pkg::GAIN_W-1:0]           gain_sel;
  logic signed [cspd_pkg::POS_W:0]       pos_diff;
  logic signed [cspd_pkg::OPB_W-1:0]     taps [cspd_pkg::HIST_TAPS];
  logic signed [cspd_pkg::ACC_W-1:0]     acc_rnd;
  logic signed [cspd_pkg::ACC_W-1:0]     q_full;
  logic signed [cspd_pkg::Q_W-1:0]       q;
  logic signed [cspd_pkg::Q_W-1:0]       lim_ext;
  logic signed [cspd_pkg::DRIVE_W-1:0]   lim_d;
  logic                                  clip_hi, clip_lo;

  assign busy     = (phase_r != PH_IDLE);
  assign do_outer = (tick_r >= cfg.period);
  assign gain_sel = mode_r ? cfg.gain_z : cfg.gain_n;
  assign pos_diff = {pos_r[cspd_pkg::POS_W-1], pos_r} - {prev_r[cspd_pkg::POS_W-1], prev_r};
  assign last_step = (phase_r == PH_WB) && (op_r == OP_TAP) && (tap_r == LAST_TAP);
  assign done = last_step && out_free;

  always_comb begin
    taps[0] = pd_r;
    for (int k = 1; k < cspd_pkg::HIST_TAPS; k++) begin
      taps[k] = hist_r[k-1];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (op_r)
      OP_GD: begin
        op_a = gain_sel;
        op_b = cspd_pkg::MUL_B_W'(cspd_pkg::C03);
      end
      OP_TP: begin
        op_a = gain_sel;
        op_b = cspd_pkg::MUL_B_W'(pos_r);
      end
      OP_TD: begin
        op_a = gd_r;
        op_b = cspd_pkg::MUL_B_W'(pos_diff);
      end
      OP_EW: begin
        op_a = cfg.tgt_w;
        op_b = cspd_pkg::MUL_B_W'(target_r);
      end
      OP_EG: begin
        op_a = cfg.gyro_w;
        op_b = cspd_pkg::MUL_B_W'(gyro_r);
      end
      OP_PK: begin
        op_a = cfg.kp;
        op_b = cspd_pkg::MUL_B_W'(err_r);
      end
      OP_PD: begin
        op_a = cfg.kd;
        op_b = cspd_pkg::MUL_B_W'(err_r) - cspd_pkg::MUL_B_W'(last_r);
      end
      OP_TAP: begin
        op_a = cspd_pkg::tap_weight(int'(tap_r));
        op_b = cspd_pkg::MUL_B_W'(taps[tap_r]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    mac_ctrl.en  = (phase_r == PH_LO) || (phase_r == PH_HI);
    mac_ctrl.hi  = (phase_r == PH_HI);
    mac_ctrl.clr = (phase_r == PH_LO) &&
                   ((op_r == OP_GD) || (op_r == OP_TP) || (op_r == OP_EW) ||
                    (op_r == OP_PK) || ((op_r == OP_TAP) && (tap_r == '0)));
    mac_ctrl.shr = (phase_r == PH_WB) && (op_r == OP_EW);
  end

  // truncate toward zero, then clamp
  always_comb begin
    acc_rnd = acc + {{(cspd_pkg::ACC_W-2*cspd_pkg::FRAC_BITS){1'b0}},
                     {(2*cspd_pkg::FRAC_BITS){acc[cspd_pkg::ACC_W-1]}}};
    q_full  = acc_rnd >>> (2 * cspd_pkg::FRAC_BITS);
    q       = q_full[cspd_pkg::Q_W-1:0];
    lim_ext = {{(cspd_pkg::Q_W-cspd_pkg::LIMIT_W){1'b0}}, cfg.limit};
    lim_d   = {1'b0, cfg.limit};
    clip_hi = (q > lim_ext);
    clip_lo = (q < -lim_ext);
    clamped = clip_hi || clip_lo;
    if (clip_hi) begin
      drive = lim_d;
    end else if (clip_lo) begin
      drive = -lim_d;
    end else begin
      drive = q[cspd_pkg::DRIVE_W-1:0];
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    op_nxt     = op_r;
    tap_nxt    = tap_r;
    tick_nxt   = tick_r;
    prev_nxt   = prev_r;
    target_nxt = target_r;
    last_nxt   = last_r;
    err_nxt    = err_r;
    pd_nxt     = pd_r;
    gd_nxt     = gd_r;
    pos_nxt    = pos_r;
    gyro_nxt   = gyro_r;
    mode_nxt   = mode_r;
    for (int k = 0; k < cspd_pkg::HIST_TAPS - 1; k++) begin
      hist_nxt[k] = hist_r[k];
    end
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_LO;
          op_nxt    = do_outer ? OP_GD : OP_EW;
          tap_nxt   = '0;
          tick_nxt  = (do_outer ? '0 : tick_r) + 1'b1;
          pos_nxt   = pos_in;
          gyro_nxt  = gyro_in;
          mode_nxt  = mode_in;
        end
      end
      PH_LO: begin
        phase_nxt = PH_HI;
      end
      PH_HI: begin
        phase_nxt = PH_WB;
      end
      PH_WB: begin
        phase_nxt = PH_LO;
        case (op_r)
          OP_GD: begin
            gd_nxt = acc[cspd_pkg::FRAC_BITS +: cspd_pkg::GAIN_W];
            op_nxt = OP_TP;
          end
          OP_TP: begin
            op_nxt = OP_TD;
          end
          OP_TD: begin
            target_nxt = acc[cspd_pkg::TGT_W-1:0];
            prev_nxt   = pos_r;
            op_nxt     = OP_EW;
          end
          OP_EW: begin
            op_nxt = OP_EG;
          end
          OP_EG: begin
            err_nxt = sat_opb(acc);
            op_nxt  = OP_PK;
          end
          OP_PK: begin
            op_nxt = OP_PD;
          end
          OP_PD: begin
            pd_nxt   = sat_opb(acc >>> cspd_pkg::FRAC_BITS);
            last_nxt = err_r;
            op_nxt   = OP_TAP;
            tap_nxt  = '0;
          end
          OP_TAP: begin
            if (tap_r != LAST_TAP) begin
              tap_nxt = tap_r + 1'b1;
            end else if (out_free) begin
              phase_nxt   = PH_IDLE;
              hist_nxt[0] = pd_r;
              for (int k = 1; k < cspd_pkg::HIST_TAPS - 1; k++) begin
                hist_nxt[k] = hist_r[k-1];
              end
            end else begin
              phase_nxt = PH_WB;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      op_r     <= OP_GD;
      tap_r    <= '0;
      tick_r   <= '0;
      prev_r   <= '0;
      target_r <= '0;
      last_r   <= '0;
      for (int k = 0; k < cspd_pkg::HIST_TAPS - 1; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      op_r     <= op_nxt;
      tap_r    <= tap_nxt;
      tick_r   <= tick_nxt;
      prev_r   <= prev_nxt;
      target_r <= target_nxt;
      last_r   <= last_nxt;
      for (int k = 0; k < cspd_pkg::HIST_TAPS - 1; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    pd_r   <= pd_nxt;
    gd_r   <= gd_nxt;
    pos_r  <= pos_nxt;
    gyro_r <= gyro_nxt;
    mode_r <= mode_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/cascaded_steering_pd_control_core.sv
// Cascaded steering PD controller: one request on in_ch per control tick
// (pos_error, gyro_z, mode) gives one request on out_ch (drive, clamped).
// Every product goes through one shared 17x25 multiply-accumulate unit, in a
// low operand-half pass, a high operand-half pass and a write-back step.
// Ticks with an outer loop update compute three extra products.
// The block takes one request at a time; in_ch.ready is low while it works
// and rises at the same edge that registers the result, so no new request
// is accepted until the current one is finished.
// The result sits in an output register until out_ch.ready takes it; the
// next request is still accepted and computed meanwhile, and the sequencer
// holds its final step until that register is free. Configuration is
// written through cfg_we/cfg_addr/cfg_wdata; the user must write it only
// while idle, since the block itself does not enforce this.
// Synchronous reset (rst_n low) restores the default gains, limit and
// period and clears the tick counter, loop state and filter history.
`default_nettype none

module cascaded_steering_pd_control_core (
  input  wire                                clk,
  input  wire                                rst_n,
  cspd_in_if.sink                            in_ch,
  cspd_out_if.source                         out_ch,
  input  wire                                cfg_we,
  input  wire [cspd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire [cspd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  cspd_pkg::cfg_regs_t                   cfg_r, cfg_nxt;
  cspd_pkg::mac_ctrl_t                   mac_ctrl;
  logic [cspd_pkg::GAIN_W-1:0]           op_a;
  logic signed [cspd_pkg::MUL_B_W-1:0]   op_b;
  logic signed [cspd_pkg::ACC_W-1:0]     acc;
  logic                                  busy;
  logic                                  start;
  logic                                  out_free;
  logic                                  done;
  logic signed [cspd_pkg::DRIVE_W-1:0]   drive;
  logic                                  clamped;
  logic                                  out_valid_r, out_valid_nxt;
  logic signed [cspd_pkg::DRIVE_W-1:0]   drive_r;
  logic                                  clamped_r;

  assign in_ch.ready = !busy;
  assign start       = in_ch.valid && !busy;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        cspd_pkg::REG_OUTER_GAIN_NORMAL: cfg_nxt.gain_n = cfg_wdata;
        cspd_pkg::REG_OUTER_GAIN_ZEBRA:  cfg_nxt.gain_z = cfg_wdata;
        cspd_pkg::REG_TARGET_WEIGHT:     cfg_nxt.tgt_w  = cfg_wdata;
        cspd_pkg::REG_GYRO_WEIGHT:       cfg_nxt.gyro_w = cfg_wdata;
        cspd_pkg::REG_INNER_KP:          cfg_nxt.kp     = cfg_wdata;
        cspd_pkg::REG_INNER_KD:          cfg_nxt.kd     = cfg_wdata;
        cspd_pkg::REG_DRIVE_LIMIT: begin
          cfg_nxt.limit = cfg_wdata[cspd_pkg::LIMIT_W-1:0];
        end
        cspd_pkg::REG_OUTER_PERIOD: begin
          cfg_nxt.period = cfg_wdata[cspd_pkg::PERIOD_W-1:0];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_n <= cspd_pkg::RST_GAIN_NORMAL;
      cfg_r.gain_z <= cspd_pkg::RST_GAIN_ZEBRA;
      cfg_r.tgt_w  <= cspd_pkg::RST_TGT_WEIGHT;
      cfg_r.gyro_w <= cspd_pkg::RST_GYRO_WEIGHT;
      cfg_r.kp     <= cspd_pkg::RST_INNER_KP;
      cfg_r.kd     <= cspd_pkg::RST_INNER_KD;
      cfg_r.limit  <= cspd_pkg::RST_LIMIT;
      cfg_r.period <= cspd_pkg::RST_PERIOD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cspd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .start    (start),
    .pos_in   (in_ch.pos_error),
    .gyro_in  (in_ch.gyro_z),
    .mode_in  (in_ch.mode),
    .out_free (out_free),
    .acc      (acc),
    .busy     (busy),
    .mac_ctrl (mac_ctrl),
    .op_a     (op_a),
    .op_b     (op_b),
    .done     (done),
    .drive    (drive),
    .clamped  (clamped)
  );

  cspd_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      drive_r   <= drive;
      clamped_r <= clamped;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.drive   = drive_r;
  assign out_ch.clamped = clamped_r;

endmodule

`default_nettype wire

>>> bench/tb_cascaded_steering_pd_control_core.sv
`default_nettype none

module tb_cascaded_steering_pd_control_core;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 115;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [cspd_pkg::DRIVE_W-1:0] drive;
    logic                                clamped;
  } drive_result_t;

  // tracks loop state and the drive values still owed by the block
  class drive_predictor;
    localparam int Q = 8;
    localparam longint GAIN_D = (3 * 256 * 2 + 10) / 20;
    localparam longint W0 = (8 * 256 * 2 + 10) / 20;
    localparam longint W1 = (1 * 256 * 2 + 10) / 20;
    localparam longint W2 = (6 * 256 * 2 + 100) / 200;
    localparam longint W3 = (4 * 256 * 2 + 100) / 200;

    cspd_pkg::cfg_regs_t cfg;
    logic [cspd_pkg::PERIOD_W-1:0] tick;
    longint prev_pos;
    longint target;
    longint last_err;
    longint pd_hist [3];
    drive_result_t expected_q [$];
    int mismatch_count;
    int checked_count;
    int clamp_count;

    function new();
      cfg.gain_n = 16'd1280;
      cfg.gain_z = 16'd2560;
      cfg.tgt_w  = 16'd2637;
      cfg.gyro_w = 16'd74;
      cfg.kp     = 16'd115;
      cfg.kd     = 16'd115;
      cfg.limit  = 11'd550;
      cfg.period = 4'd3;
      tick = '0;
      prev_pos = 0;
      target = 0;
      last_err = 0;
      foreach (pd_hist[i]) pd_hist[i] = 0;
      mismatch_count = 0;
      checked_count = 0;
      clamp_count = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [cspd_pkg::CFG_ADDR_W-1:0] idx,
                            logic [cspd_pkg::CFG_DATA_W-1:0] word);
      case (idx)
        cspd_pkg::REG_OUTER_GAIN_NORMAL: cfg.gain_n = word;
        cspd_pkg::REG_OUTER_GAIN_ZEBRA:  cfg.gain_z = word;
        cspd_pkg::REG_TARGET_WEIGHT:     cfg.tgt_w = word;
        cspd_pkg::REG_GYRO_WEIGHT:       cfg.gyro_w = word;
        cspd_pkg::REG_INNER_KP:          cfg.kp = word;
        cspd_pkg::REG_INNER_KD:          cfg.kd = word;
        cspd_pkg::REG_DRIVE_LIMIT:       cfg.limit = word[cspd_pkg::LIMIT_W-1:0];
        cspd_pkg::REG_OUTER_PERIOD:      cfg.period = word[cspd_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function longint sat64(wide_t v);
      if (v > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (v < -128'sh7FFF_FFFF_FFFF_FFFF) return -64'sh7FFF_FFFF_FFFF_FFFF;
      return longint'(v);
    endfunction

    function longint mul_sat(longint a, longint b);
      return sat64(wide_t'(a) * wide_t'(b));
    endfunction

    function longint add_sat(longint a, longint b);
      return sat64(wide_t'(a) + wide_t'(b));
    endfunction

    function longint clip(longint v, int bits);
      longint lim;
      lim = (longint'(1) <<< (bits - 1)) - 1;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void note_request(logic signed [cspd_pkg::POS_W-1:0] pos,
                               logic signed [cspd_pkg::GYRO_W-1:0] gyro, logic mode);
      longint p, g, gd, err, pd, acc, drv, lim;
      drive_result_t r;
      p = longint'(pos);
      // outer loop: yaw target from position error
      if (tick >= cfg.period) begin
        g = mode ? longint'(cfg.gain_z) : longint'(cfg.gain_n);
        gd = (g * GAIN_D) >>> Q;
        target = clip(add_sat(mul_sat(g, p), mul_sat(gd, p - prev_pos)), cspd_pkg::TGT_W);
        prev_pos = p;
        tick = '0;
      end
      tick = tick + 4'd1;
      // inner loop on weighted target and gyro rate
      err = add_sat(mul_sat(longint'(cfg.tgt_w), target) >>> Q,
                    mul_sat(longint'(cfg.gyro_w), longint'(gyro)));
      err = clip(err, cspd_pkg::OPB_W);
      pd = add_sat(mul_sat(longint'(cfg.kp), err),
                   mul_sat(longint'(cfg.kd), err - last_err));
      pd = clip(pd >>> Q, cspd_pkg::OPB_W);
      last_err = err;
      // weighted history smoothing
      acc = mul_sat(W0, pd);
      acc = add_sat(acc, mul_sat(W1, pd_hist[0]));
      acc = add_sat(acc, mul_sat(W2, pd_hist[1]));
      acc = add_sat(acc, mul_sat(W3, pd_hist[2]));
      pd_hist[2] = pd_hist[1];
      pd_hist[1] = pd_hist[0];
      pd_hist[0] = pd;
      drv = (acc >= 0) ? (acc >>> (2 * Q)) : -((-acc) >>> (2 * Q));
      lim = longint'(cfg.limit);
      r.clamped = 1'b0;
      if (drv > lim) begin
        drv = lim;
        r.clamped = 1'b1;
      end
      if (drv < -lim) begin
        drv = -lim;
        r.clamped = 1'b1;
      end
      r.drive = cspd_pkg::DRIVE_W'(drv);
      expected_q.push_back(r);
    endfunction

    task report(string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch %0d: %s", mismatch_count, what);
    endtask

    task check_result(logic signed [cspd_pkg::DRIVE_W-1:0] drive, logic clamped);
      drive_result_t e;
      checked_count++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d with nothing expected: drive %0d", checked_count, drive));
        return;
      end
      e = expected_q.pop_front();
      if (e.clamped) clamp_count++;
      if (drive !== e.drive)
        report($sformatf("result %0d: drive %0d, expected %0d", checked_count, drive, e.drive));
      if (clamped !== e.clamped)
        report($sformatf("result %0d: clamped %0b, expected %0b", checked_count, clamped,
                         e.clamped));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [cspd_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [cspd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  cspd_in_if  in_ch ();
  cspd_out_if out_ch ();

  cascaded_steering_pd_control_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  drive_predictor sb;
  logic [cspd_pkg::CFG_DATA_W-1:0] cfg_words [8];
  int burst_left;
  int sent_count;
  int settings_count;
  int long_holds;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // send one control tick, idling between bursts
  task automatic offer(int pos, int gyro, logic mode);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_ch.pos_error <= cspd_pkg::POS_W'(pos);
    in_ch.gyro_z <= cspd_pkg::GYRO_W'(gyro);
    in_ch.mode <= mode;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_request(cspd_pkg::POS_W'(pos), cspd_pkg::GYRO_W'(gyro), mode);
    burst_left--;
    sent_count++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_settings();
    for (int i = 0; i < 8; i++) begin
      cfg_addr <= cspd_pkg::CFG_ADDR_W'(i);
      cfg_wdata <= cfg_words[i];
      cfg_we <= 1'b1;
      @(posedge clk);
      sb.write_reg(cspd_pkg::CFG_ADDR_W'(i), cfg_words[i]);
    end
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic roll_settings();
    logic [cspd_pkg::LIMIT_W-1:0] lim;
    logic [cspd_pkg::PERIOD_W-1:0] per;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 4))
        0: cfg_words[i] = cspd_pkg::CFG_DATA_W'($urandom);
        1: cfg_words[i] = cspd_pkg::CFG_DATA_W'($urandom_range(0, 512));
        2: cfg_words[i] = cspd_pkg::CFG_DATA_W'($urandom_range(0, 64));
        3: cfg_words[i] = '0;
        default: cfg_words[i] = cspd_pkg::CFG_DATA_W'($urandom_range(60, 3000));
      endcase
    end
    case ($urandom_range(0, 3))
      0: lim = '0;
      1: lim = '1;
      default: lim = cspd_pkg::LIMIT_W'($urandom);
    endcase
    per = ($urandom_range(0, 3) == 0) ? cspd_pkg::PERIOD_W'($urandom_range(0, 15)) :
                                        cspd_pkg::PERIOD_W'($urandom_range(0, 4));
    cfg_words[cspd_pkg::REG_DRIVE_LIMIT] = {5'($urandom), lim};
    cfg_words[cspd_pkg::REG_OUTER_PERIOD] = {12'($urandom), per};
  endtask

  task automatic random_request();
    int pos;
    int gyro;
    case ($urandom_range(0, 4))
      0: pos = int'($urandom_range(0, 2047)) - 1024;
      1: pos = int'($urandom_range(0, 32)) - 16;
      2: pos = ($urandom_range(0, 1) != 0) ? 1023 : -1024;
      default: pos = int'($urandom_range(0, 400)) - 200;
    endcase
    case ($urandom_range(0, 4))
      0: gyro = int'($urandom_range(0, 65535)) - 32768;
      1: gyro = int'($urandom_range(0, 128)) - 64;
      2: gyro = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: gyro = int'($urandom_range(0, 6000)) - 3000;
    endcase
    offer(pos, gyro, 1'($urandom_range(0, 1)));
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.drive, out_ch.clamped);
  end

  // receiver stall pattern, with a long hold-off every few segments
  initial begin
    int seg;
    int kind;
    int len;
    int span;
    out_ch.ready <= 1'b0;
    seg = 0;
    long_holds = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      seg++;
      if (seg % 7 == 3) begin
        out_ch.ready <= 1'b0;
        long_holds++;
        repeat ($urandom_range(300, 600)) @(posedge clk);
      end else begin
        kind = $urandom_range(0, 2);
        len = $urandom_range(20, 200);
        span = $urandom_range(2, 6);
        for (int c = 0; c < len; c++) begin
          case (kind)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= (c % span) != 0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    sb = new();
    burst_left = 0;
    sent_count = 0;
    settings_count = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.pos_error <= '0;
    in_ch.gyro_z <= '0;
    in_ch.mode <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains, field extremes
    offer(0, 0, 1'b0);
    offer(1023, 0, 1'b0);
    offer(-1024, 0, 1'b0);
    offer(0, 32767, 1'b0);
    offer(0, -32768, 1'b1);
    offer(1023, 32767, 1'b1);
    offer(-1024, -32768, 1'b1);
    offer(1023, -32768, 1'b0);
    offer(-1024, 32767, 1'b1);
    offer(5, -300, 1'b0);
    drain();

    // every register at its top value, long outer period
    cfg_words = '{default: 16'hFFFF};
    apply_settings();
    offer(1023, 32767, 1'b1);
    offer(-1024, -32768, 1'b0);
    offer(1023, -32768, 1'b1);
    offer(-1024, 32767, 1'b0);
    offer(1023, 32767, 1'b0);
    offer(-1024, -32768, 1'b1);
    offer(1023, 32767, 1'b1);
    offer(0, 0, 1'b0);
    drain();

    // period shortened below the running tick count
    cfg_words[cspd_pkg::REG_OUTER_PERIOD] = 16'hFFF2;
    cfg_words[cspd_pkg::REG_DRIVE_LIMIT] = 16'h0123;
    apply_settings();
    offer(-1024, 100, 1'b1);
    offer(700, -100, 1'b0);
    offer(-3, 32767, 1'b1);
    drain();

    // zero period and zero limit
    cfg_words = '{default: 16'h0000};
    cfg_words[cspd_pkg::REG_OUTER_GAIN_NORMAL] = 16'd1280;
    cfg_words[cspd_pkg::REG_OUTER_GAIN_ZEBRA] = 16'd2560;
    cfg_words[cspd_pkg::REG_TARGET_WEIGHT] = 16'd2637;
    cfg_words[cspd_pkg::REG_INNER_KP] = 16'd115;
    apply_settings();
    offer(100, 0, 1'b0);
    offer(-100, 5000, 1'b1);
    offer(1, 0, 1'b0);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      roll_settings();
      apply_settings();
      repeat (ITEMS_PER_PHASE) random_request();
      drain();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d control ticks under %0d register settings, %0d clamped drives",
             sent_count, settings_count + 1, sb.clamp_count);
    $display("%0d results checked, %0d long receiver hold-offs, %0d mismatches",
             sb.checked_count, long_holds, sb.mismatch_count);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
